/* hw/rtl/dcc_pkg.sv */
// Shared constants and types for the dependency cycle check block.
package dcc_pkg;

    localparam logic REQ_ADD_EDGE = 1'b0;
    localparam logic REQ_CHECK    = 1'b1;

    localparam int CFG_WIDTH   = 9;
    localparam int FIELD_WIDTH = 8;

    typedef struct packed {
        logic       can_finish;
        logic [8:0] nodes_ordered;
        logic       edge_overflow;
        logic       node_out_of_range;
    } result_t;

endpackage

/* hw/rtl/dcc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/dependency_cycle_check.sv */
// Top level of the dependency cycle check: edge loading and Kahn walk sequencer.
//
//  channel | direction | handshake       | content
//  --------+-----------+-----------------+------------------------------------------
//  in      | input     | in_valid/stall  | req_type, dependent_node, required_node
//  out     | output    | out_valid/stall | can_finish, nodes_ordered, flags
//  cfg     | input     | valid/ready     | node_count
//
// An edge transfer reads the list head and in-degree, then writes both back;
// a dropped edge only sets its flag. A check scans the in-degrees node by node,
// then pops each ready node (queue read, then head read) and follows its edges
// (edge read, then degree update), paced by the single read port of each memory.
// Then a clearing pass resets degrees and heads.
// After reset the same clearing pass runs first; no input is taken during it.
// A stalled result is held in the output register; edge transfers go on meanwhile,
// and the next check holds in its last step until the waiting result is taken.
module dependency_cycle_check #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] dependent_node,
    input  logic [7:0] required_node,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       can_finish,
    output logic [8:0] nodes_ordered,
    output logic       edge_overflow,
    output logic       node_out_of_range,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_node_count
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = NW + 1;
    localparam int TW = EW + 1;
    localparam int DW = EW + 2;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ADD   = 4'd2;
    localparam logic [3:0] ST_SCANR = 4'd3;
    localparam logic [3:0] ST_SCAN  = 4'd4;
    localparam logic [3:0] ST_POP   = 4'd5;
    localparam logic [3:0] ST_HEAD  = 4'd6;
    localparam logic [3:0] ST_EDGE  = 4'd7;
    localparam logic [3:0] ST_DEG   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;
    localparam logic [3:0] ST_QRD   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [8:0]    count_reg;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [TW-1:0] etot_reg, etot_next;
    logic          ovf_reg, ovf_next, oor_reg, oor_next;
    logic [NW-1:0] dep_reg, dep_next, req_reg, req_next;
    logic [EW-1:0] edge_reg, edge_next_r;
    logic [NW-1:0] tgt_reg, tgt_next;
    logic          more_reg, more_next;
    logic          res_v_reg;
    dcc_pkg::result_t res_reg, res_next;
    logic          res_load;

    // effective node count, capped at MAX_NODES
    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_NODES))
            n_eff = CW'(MAX_NODES);
        else
            n_eff = CW'(count_reg);
    end

    // degree memory: {degree}
    logic          deg_we;
    logic [NW-1:0] deg_wa, deg_ra;
    logic [DW-1:0] deg_wd, deg_rd;
    // head memory: {valid, edge}
    logic          hd_we;
    logic [NW-1:0] hd_wa, hd_ra;
    logic [EW:0]   hd_wd, hd_rd;
    // edge memory: {next_valid, next, target}
    logic          ed_we;
    logic [EW-1:0] ed_wa, ed_ra;
    logic [EW+NW:0] ed_wd, ed_rd;
    // ready queue
    logic          q_we;
    logic [NW-1:0] q_wa, q_ra;
    logic [NW-1:0] q_wd, q_rd;

    dcc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (
        .clk(clk), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
        .rd_addr(deg_ra), .rd_data(deg_rd));
    dcc_ram #(.WIDTH(EW + 1), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
        .rd_addr(hd_ra), .rd_data(hd_rd));
    dcc_ram #(.WIDTH(EW + NW + 1), .DEPTH(MAX_EDGES)) u_edge (
        .clk(clk), .wr_en(ed_we), .wr_addr(ed_wa), .wr_data(ed_wd),
        .rd_addr(ed_ra), .rd_data(ed_rd));
    dcc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
        .rd_addr(q_ra), .rd_data(q_rd));

    logic in_take;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    logic out_take;
    assign out_take = res_v_reg && !out_stall;

    logic [DW-1:0] deg_dec;
    assign deg_dec = deg_rd - DW'(1);

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        etot_next   = etot_reg;
        ovf_next    = ovf_reg;
        oor_next    = oor_reg;
        dep_next    = dep_reg;
        req_next    = req_reg;
        edge_next_r = edge_reg;
        tgt_next    = tgt_reg;
        more_next   = more_reg;
        res_next    = res_reg;
        res_load    = 1'b0;
        deg_we = 1'b0; deg_wa = dep_reg; deg_wd = '0; deg_ra = dep_reg;
        hd_we  = 1'b0; hd_wa  = req_reg; hd_wd  = '0; hd_ra  = req_reg;
        ed_we  = 1'b0; ed_wa  = etot_reg[EW-1:0]; ed_wd = '0; ed_ra = edge_reg;
        q_we   = 1'b0; q_wa   = wr_reg[NW-1:0]; q_wd = '0; q_ra = rd_reg[NW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                deg_we = 1'b1; deg_wa = ptr_reg[NW-1:0];
                hd_we  = 1'b1; hd_wa  = ptr_reg[NW-1:0];
                ptr_next = ptr_reg + CW'(1);
                if (ptr_reg == CW'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (req_type == dcc_pkg::REQ_CHECK)
                    begin
                        ptr_next   = '0;
                        wr_next    = '0;
                        rd_next    = '0;
                        deg_ra     = '0;
                        state_next = ST_SCANR;
                    end
                    else if (32'(dependent_node) >= 32'(n_eff)
                             || 32'(required_node) >= 32'(n_eff))
                    begin
                        oor_next = 1'b1;
                    end
                    else if (etot_reg >= TW'(MAX_EDGES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        dep_next   = NW'(dependent_node);
                        req_next   = NW'(required_node);
                        deg_ra     = NW'(dependent_node);
                        hd_ra      = NW'(required_node);
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                // link the new edge in front of the source's list
                ed_we  = 1'b1;
                ed_wd  = {hd_rd[EW], hd_rd[EW-1:0], dep_reg};
                hd_we  = 1'b1;
                hd_wd  = {1'b1, etot_reg[EW-1:0]};
                deg_we = 1'b1;
                deg_wd = deg_rd + DW'(1);
                etot_next  = etot_reg + TW'(1);
                state_next = ST_IDLE;
            end
            ST_SCANR:
            begin
                if (ptr_reg >= n_eff)
                    state_next = ST_POP;
                else
                begin
                    deg_ra     = ptr_reg[NW-1:0];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (deg_rd == '0)
                begin
                    q_we = 1'b1; q_wd = ptr_reg[NW-1:0];
                    wr_next = wr_reg + CW'(1);
                end
                ptr_next = ptr_reg + CW'(1);
                if (ptr_reg + CW'(1) >= n_eff)
                    state_next = ST_POP;
                else
                    deg_ra = NW'(ptr_reg + CW'(1));
            end
            ST_POP:
            begin
                if (rd_reg == wr_reg)
                    state_next = ST_DONE;
                else
                begin
                    rd_next    = rd_reg + CW'(1);
                    state_next = ST_QRD;
                end
            end
            ST_QRD:
            begin
                hd_ra      = q_rd;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (hd_rd[EW])
                begin
                    ed_ra       = hd_rd[EW-1:0];
                    edge_next_r = hd_rd[EW-1:0];
                    state_next  = ST_EDGE;
                end
                else
                    state_next = ST_POP;
            end
            ST_EDGE:
            begin
                tgt_next    = ed_rd[NW-1:0];
                more_next   = ed_rd[EW+NW];
                edge_next_r = ed_rd[EW+NW-1:NW];
                deg_ra      = ed_rd[NW-1:0];
                state_next  = ST_DEG;
            end
            ST_DEG:
            begin
                if (deg_rd != '0)
                begin
                    deg_we = 1'b1; deg_wa = tgt_reg; deg_wd = deg_dec;
                    if (deg_dec == '0 && CW'(tgt_reg) < n_eff)
                    begin
                        q_we = 1'b1; q_wd = tgt_reg;
                        wr_next = wr_reg + CW'(1);
                    end
                end
                if (more_reg)
                begin
                    ed_ra      = edge_reg;
                    state_next = ST_EDGE;
                end
                else
                    state_next = ST_POP;
            end
            ST_DONE:
            begin
                // hold here while the previous result still waits
                if (!res_v_reg || out_take)
                begin
                    res_load = 1'b1;
                    res_next.can_finish        = (rd_reg == n_eff);
                    res_next.nodes_ordered     = 9'(rd_reg);
                    res_next.edge_overflow     = ovf_reg;
                    res_next.node_out_of_range = oor_reg;
                    etot_next  = '0;
                    ovf_next   = 1'b0;
                    oor_next   = 1'b0;
                    ptr_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            count_reg <= 9'd256;
            ptr_reg   <= '0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            etot_reg  <= '0;
            ovf_reg   <= 1'b0;
            oor_reg   <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            etot_reg  <= etot_next;
            ovf_reg   <= ovf_next;
            oor_reg   <= oor_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_node_count;
            if (res_load)
                res_v_reg <= 1'b1;
            else if (out_take)
                res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dep_reg  <= dep_next;
        req_reg  <= req_next;
        edge_reg <= edge_next_r;
        tgt_reg  <= tgt_next;
        more_reg <= more_next;
        res_reg  <= res_next;
    end

    assign out_valid         = res_v_reg;
    assign can_finish        = res_reg.can_finish;
    assign nodes_ordered     = res_reg.nodes_ordered;
    assign edge_overflow     = res_reg.edge_overflow;
    assign node_out_of_range = res_reg.node_out_of_range;

endmodule

/* hw/rtl/dcc_checker.sv */
// Port-level checks for the dependency cycle check block, bound to the top level.
module dcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       can_finish,
    input logic [8:0] nodes_ordered,
    input logic       edge_overflow,
    input logic       node_out_of_range
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({can_finish, nodes_ordered, edge_overflow, node_out_of_range}))
        else $error("stalled result changed");

    // a shown result carries known values
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({can_finish, nodes_ordered, edge_overflow,
                                   node_out_of_range}))
        else $error("result has unknown bits");

    // no new result appears the cycle after an input transfer
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

    // the clearing pass holds off input right after reset
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input open before clearing pass");

endmodule

bind dependency_cycle_check dcc_checker u_dcc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .can_finish(can_finish),
    .nodes_ordered(nodes_ordered), .edge_overflow(edge_overflow),
    .node_out_of_range(node_out_of_range));

/* sim/dcc_checker.sv */
// Checker for the dependency cycle check: predicts each check result and compares it.
module dcc_scoreboard (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] dependent_node,
    input  logic [7:0] required_node,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       can_finish,
    input  logic [8:0] nodes_ordered,
    input  logic       edge_overflow,
    input  logic       node_out_of_range,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [8:0] cfg_node_count,
    output int         fail_count,
    output int         pending
);

    localparam int NODES = 256;
    localparam int EDGES = 1024;

    logic [8:0]  node_limit;
    logic [10:0] indeg [NODES];
    logic [10:0] list_head [NODES];
    bit          head_live [NODES];
    logic [10:0] link_next [EDGES];
    bit          link_live [EDGES];
    logic [7:0]  link_dst [EDGES];
    logic [10:0] links_held;
    logic [1:0]  err_flags;
    logic [7:0]  ready_list [NODES];
    dcc_pkg::result_t verdicts_due [$];

    function automatic int live_nodes();
        return (node_limit > NODES) ? NODES : int'(node_limit);
    endfunction

    function automatic void forget_graph();
        for (int i = 0; i < NODES; i++)
        begin
            indeg[i]     = '0;
            list_head[i] = '0;
            head_live[i] = 1'b0;
        end
        links_held = '0;
        err_flags  = '0;
    endfunction

    function automatic void record_edge(logic [7:0] dst, logic [7:0] src);
        int n;
        n = live_nodes();
        if (dst >= n || src >= n)
            err_flags[1] = 1'b1;
        else if (links_held >= EDGES)
            err_flags[0] = 1'b1;
        else
        begin
            link_dst[links_held]  = dst;
            link_next[links_held] = list_head[src];
            link_live[links_held] = head_live[src];
            list_head[src]        = links_held;
            head_live[src]        = 1'b1;
            links_held            = links_held + 11'd1;
            indeg[dst]            = indeg[dst] + 11'd1;
        end
    endfunction

    // Kahn walk; returns the number of nodes popped
    function automatic int count_ordered();
        int n, wr, rd, e, t, node;
        bit more;
        n  = live_nodes();
        wr = 0;
        rd = 0;
        for (int i = 0; i < n; i++)
            if (indeg[i] == 0)
            begin
                ready_list[wr] = i[7:0];
                wr++;
            end
        while (rd < wr)
        begin
            node = int'(ready_list[rd]);
            rd++;
            more = head_live[node];
            e    = int'(list_head[node]);
            while (more)
            begin
                t = int'(link_dst[e]);
                if (indeg[t] != 0)
                begin
                    indeg[t] = indeg[t] - 11'd1;
                    if (indeg[t] == 0 && t < n && wr < NODES)
                    begin
                        ready_list[wr] = t[7:0];
                        wr++;
                    end
                end
                more = link_live[e];
                e    = int'(link_next[e]);
            end
        end
        return rd;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        if (fail_count < 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        fail_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dcc_pkg::result_t want;
        int ordered;
        if (!rst_n)
        begin
            node_limit = 9'd256;
            forget_graph();
            verdicts_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                node_limit = cfg_node_count;
            if (in_valid && !in_stall)
            begin
                if (req_type == dcc_pkg::REQ_ADD_EDGE)
                    record_edge(dependent_node, required_node);
                else
                begin
                    ordered                = count_ordered();
                    want.can_finish        = (ordered == live_nodes());
                    want.nodes_ordered     = ordered[8:0];
                    want.edge_overflow     = err_flags[0];
                    want.node_out_of_range = err_flags[1];
                    verdicts_due           = {verdicts_due, want};
                    forget_graph();
                end
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    note_mismatch("unexpected result, count", 0, 1);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (can_finish !== want.can_finish)
                        note_mismatch("can_finish", want.can_finish, can_finish);
                    if (nodes_ordered !== want.nodes_ordered)
                        note_mismatch("nodes_ordered", want.nodes_ordered, nodes_ordered);
                    if (edge_overflow !== want.edge_overflow)
                        note_mismatch("edge_overflow", want.edge_overflow, edge_overflow);
                    if (node_out_of_range !== want.node_out_of_range)
                        note_mismatch("node_out_of_range", want.node_out_of_range,
                                      node_out_of_range);
                end
            end
            pending = verdicts_due.size();
        end
    end

endmodule

/* sim/tb_dependency_cycle_check.sv */
// Testbench top for the dependency cycle check: stimulus, idling and verdict.
module tb_dependency_cycle_check;

    // a full check walk with a full store, plus the clearing pass and the long
    // receiver hold-off; allow several times that
    localparam int STALL_LIMIT = 40000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       req_type;
    logic [7:0] dependent_node;
    logic [7:0] required_node;
    logic       out_valid;
    logic       out_stall;
    logic       can_finish;
    logic [8:0] nodes_ordered;
    logic       edge_overflow;
    logic       node_out_of_range;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [8:0] cfg_node_count;
    int         fail_count;
    int         pending;

    int         nodes_now;     // effective node count as last written
    int         items_sent;
    bit         quiet;         // no idling on either side
    bit         hold_long;     // ask the receiver for one long hold-off
    int         idle_cycles;

    dependency_cycle_check dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .dependent_node    (dependent_node),
        .required_node     (required_node),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .can_finish        (can_finish),
        .nodes_ordered     (nodes_ordered),
        .edge_overflow     (edge_overflow),
        .node_out_of_range (node_out_of_range),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_node_count    (cfg_node_count)
    );

    dcc_scoreboard u_scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .dependent_node    (dependent_node),
        .required_node     (required_node),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .can_finish        (can_finish),
        .nodes_ordered     (nodes_ordered),
        .edge_overflow     (edge_overflow),
        .node_out_of_range (node_out_of_range),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_node_count    (cfg_node_count),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Offer one transfer; idle for a random burst first unless quiet.
    // Stall is sampled at the falling edge, where it has settled.
    task automatic send_request(logic kind, logic [7:0] dst, logic [7:0] src);
        int gap;
        bit taken;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        dependent_node <= dst;
        required_node  <= src;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic add_edge(int dst, int src);
        send_request(dcc_pkg::REQ_ADD_EDGE, dst[7:0], src[7:0]);
    endtask

    task automatic run_check();
        send_request(dcc_pkg::REQ_CHECK, 8'($urandom()), 8'($urandom()));
    endtask

    // Write the node count once the block has drained; edge transfers give no
    // result, so the task also waits for the last one to settle.
    task automatic write_node_count(int value);
        bit taken;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        cfg_valid      <= 1'b1;
        cfg_node_count <= value[8:0];
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        nodes_now = (value > 256) ? 256 : value;
    endtask

    // One random graph: mostly acyclic edges, some back edges, self-loops and
    // out-of-range nodes; then the check.
    task automatic random_graph(int edges, bit cyclic);
        int a, b, roll;
        for (int k = 0; k < edges; k++)
        begin
            roll = $urandom_range(0, 99);
            if (nodes_now == 0 || roll < 4)
                add_edge($urandom_range(0, 255), $urandom_range(0, 255));
            else
            begin
                a = $urandom_range(0, nodes_now - 1);
                b = $urandom_range(0, nodes_now - 1);
                if (cyclic && roll < 12)
                    add_edge(a, b);
                else if (cyclic && roll < 15)
                    add_edge(a, a);
                else if (a > b)
                    add_edge(a, b);
                else if (a < b)
                    add_edge(b, a);
                else
                    add_edge(a, nodes_now - 1 - a);
            end
        end
        run_check();
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    // The hold-off outlasts the next check's walk, so that check fills the block.
    initial
    begin
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int settings [8];
        int phase;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        req_type       <= dcc_pkg::REQ_ADD_EDGE;
        dependent_node <= '0;
        required_node  <= '0;
        cfg_valid      <= 1'b0;
        cfg_node_count <= '0;
        nodes_now      = 256;
        items_sent     = 0;
        quiet          = 1'b0;
        hold_long      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty graph at the reset count, a two-node cycle, a self-loop
        run_check();
        add_edge(255, 0);
        add_edge(0, 255);
        run_check();
        add_edge(7, 7);
        run_check();
        // count of zero: every edge is out of range, the graph is empty
        write_node_count(0);
        add_edge(0, 0);
        run_check();
        // count above the cap behaves as the cap
        write_node_count(511);
        add_edge(255, 254);
        run_check();
        write_node_count(16);
        add_edge(3, 2);
        add_edge(20, 1);
        add_edge(1, 200);
        run_check();
        // lower the count after loading: kept edges still weigh on their targets
        add_edge(5, 12);
        add_edge(12, 3);
        add_edge(2, 1);
        add_edge(9, 15);
        write_node_count(8);
        run_check();
        write_node_count(1);
        add_edge(0, 0);
        run_check();

        // Fill the edge store past its capacity in one graph
        write_node_count(256);
        for (int k = 0; k < 1030; k++)
            add_edge($urandom_range(1, 255), 0);
        run_check();

        // Random graphs over a spread of counts; press on the receiver once
        settings = '{2, 40, 255, 9, 128, 3, 256, 17};
        phase    = 0;
        while (items_sent < 1750)
        begin
            if (phase % 6 == 0)
                write_node_count((phase / 6 == 3) ? $urandom_range(0, 511)
                                 : settings[(phase / 6) % 8]);
            if (phase == 20)
            begin
                run_check();
                hold_long = 1'b1;
            end
            quiet = (items_sent > 1600);
            random_graph($urandom_range(0, 30), $urandom_range(0, 2) == 0);
            phase++;
        end
        in_valid <= 1'b0;

        // Drain, then let the clearing pass finish
        do
            @(negedge clk);
        while (pending != 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
